/* hdl/double_ended_queue_core_assert.svh */
// Assertion macros shared by the deque checker
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// check cons in the cycle after ante
`define DDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed: next-cycle rule");

// check cons in the same cycle as ante
`define DDQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque check failed: same-cycle rule");

`endif

/* hdl/ddq_pkg.sv */
// Shared types, constants and word helpers for the deque
package ddq_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int CMP_BITS  = (CNT_BITS > 4) ? CNT_BITS : 4;
  localparam int IN_BITS   = (WORD_BITS < 32) ? WORD_BITS : 32;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_READ_INDEX = 3'd6
  } op_t;

  typedef struct packed {
    logic shr;
    logic shl;
    logic ld;
  } cell_ctl_t;

  function automatic word_t to_word(input logic [31:0] v);
    word_t w;
    w = '0;
    w[IN_BITS-1:0] = v[IN_BITS-1:0];
    return w;
  endfunction

  function automatic logic [31:0] from_word(input word_t w);
    return 32'($signed(w));
  endfunction

endpackage

/* hdl/ddq_cell.sv */
// One storage cell of the shifting deque row
module ddq_cell
  import ddq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  word_t     left_word,
  input  word_t     right_word,
  input  word_t     load_word,
  output word_t     word
);

  word_t word_r;
  word_t word_nxt;

  always_comb begin
    priority if (ctl.shr) begin
      word_nxt = left_word;
    end else if (ctl.shl) begin
      word_nxt = right_word;
    end else if (ctl.ld) begin
      word_nxt = load_word;
    end else begin
      word_nxt = word_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

/* hdl/double_ended_queue_core.sv */
// Deque top level: a row of shifting cells with the front word always in cell 0.
// The block takes one operation per clock cycle and never raises busy; the
// result of an operation appears one cycle after its transfer, for exactly
// one cycle with out_valid high, and the receiver must take it then. Push at
// the front and pop from the front shift the whole row one cell in a single
// cycle; push at the back writes the cell at the current count. Pops, peeks
// and reads past the stored words return zero with out_empty_error; a push
// into a full deque is dropped with out_full_error. No clearing pass follows
// reset.
module double_ended_queue_core
  import ddq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_value,
  input  logic [3:0]  in_position,
  output logic        out_valid,
  output logic [31:0] out_word_out,
  output logic [4:0]  out_occupancy,
  output logic        out_empty_error,
  output logic        out_full_error
);

  word_t                words [DEPTH];
  cell_ctl_t            ctl   [DEPTH];
  word_t                load_word;
  logic                 xfer;
  op_t                  op;
  logic [CNT_BITS-1:0]  count_r;
  logic [CNT_BITS-1:0]  count_nxt;
  logic                 is_full;
  logic                 is_empty;
  logic                 do_push_back;
  logic                 do_push_front;
  logic                 do_pop_front;
  logic                 rd_en;
  logic                 empty_err;
  logic                 full_err;
  logic [CMP_BITS-1:0]  rd_sel;
  logic [IDX_BITS-1:0]  rd_idx;
  logic                 valid_r;
  logic [31:0]          word_r;
  logic [4:0]           occ_r;
  logic                 empty_r;
  logic                 full_r;

  assign busy      = 1'b0;
  assign xfer      = start && !busy;
  assign op        = op_t'(in_op);
  assign load_word = to_word(in_value);
  assign is_full   = (count_r == CNT_BITS'(DEPTH));
  assign is_empty  = (count_r == '0);

  always_comb begin
    do_push_back  = 1'b0;
    do_push_front = 1'b0;
    do_pop_front  = 1'b0;
    rd_en         = 1'b0;
    empty_err     = 1'b0;
    full_err      = 1'b0;
    count_nxt     = count_r;
    rd_sel        = '0;
    if (xfer) begin
      unique case (op)
        OP_PUSH_BACK: begin
          full_err     = is_full;
          do_push_back = !is_full;
          if (!is_full) count_nxt = count_r + 1'b1;
        end
        OP_PUSH_FRONT: begin
          full_err      = is_full;
          do_push_front = !is_full;
          if (!is_full) count_nxt = count_r + 1'b1;
        end
        OP_POP_BACK: begin
          empty_err = is_empty;
          rd_en     = !is_empty;
          rd_sel    = CMP_BITS'(count_r) - 1'b1;
          if (!is_empty) count_nxt = count_r - 1'b1;
        end
        OP_POP_FRONT: begin
          empty_err    = is_empty;
          rd_en        = !is_empty;
          do_pop_front = !is_empty;
          if (!is_empty) count_nxt = count_r - 1'b1;
        end
        OP_PEEK_FRONT: begin
          empty_err = is_empty;
          rd_en     = !is_empty;
        end
        OP_PEEK_BACK: begin
          empty_err = is_empty;
          rd_en     = !is_empty;
          rd_sel    = CMP_BITS'(count_r) - 1'b1;
        end
        OP_READ_INDEX: begin
          empty_err = (CMP_BITS'(in_position) >= CMP_BITS'(count_r));
          rd_en     = !empty_err;
          rd_sel    = CMP_BITS'(in_position);
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_idx = rd_sel[IDX_BITS-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctl[i].shr = do_push_front;
    assign ctl[i].shl = do_pop_front;
    assign ctl[i].ld  = do_push_back && (count_r == CNT_BITS'(i));

    ddq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .left_word  ((i == 0) ? load_word : words[(i == 0) ? 0 : i - 1]),
      .right_word ((i == DEPTH - 1) ? words[i] : words[(i == DEPTH - 1) ? i : i + 1]),
      .load_word  (load_word),
      .word       (words[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= xfer;
    end
  end

  always_ff @(posedge clk) begin
    word_r  <= rd_en ? from_word(words[rd_idx]) : 32'd0;
    occ_r   <= 5'(count_nxt);
    empty_r <= empty_err;
    full_r  <= full_err;
  end

  assign out_valid       = valid_r;
  assign out_word_out    = word_r;
  assign out_occupancy   = occ_r;
  assign out_empty_error = empty_r;
  assign out_full_error  = full_r;

endmodule

/* hdl/ddq_checker.sv */
// Port-level checker for the deque, bound to the top level
`include "double_ended_queue_core_assert.svh"

module ddq_checker
  import ddq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_word_out,
  input logic [4:0]  out_occupancy,
  input logic        out_empty_error,
  input logic        out_full_error
);

  `DDQ_ASSERT_NEXT(a_result_follows, start && !busy, out_valid)
  `DDQ_ASSERT_NEXT(a_no_stray_result, !(start && !busy), !out_valid)
  `DDQ_ASSERT_SAME(a_one_error, out_valid, !(out_empty_error && out_full_error))
  `DDQ_ASSERT_SAME(a_full_drop, out_valid && out_full_error, out_occupancy == 5'(DEPTH) && out_word_out == 32'd0)
  `DDQ_ASSERT_SAME(a_empty_zero, out_valid && out_empty_error, out_word_out == 32'd0)

endmodule

bind double_ended_queue_core ddq_checker u_ddq_checker (.*);

/* bench/tb.sv */
// Self-checking testbench for double_ended_queue_core with a ring-buffer mirror as scoreboard
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ddq_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 500;
  localparam int RANDOM_ITEMS = 1250;

  typedef enum int {FILL_BIASED, DRAIN_BIASED, MIXED} phase_mode_t;

  typedef struct {
    logic [31:0] word;
    logic [4:0]  occupancy;
    logic        empty_err;
    logic        full_err;
  } deque_reply_t;

  class deque_scoreboard;
    logic [31:0]  ring_word [DEPTH];
    int           head_slot;
    int           word_count;
    deque_reply_t awaited_replies [$];
    int           mismatches;
    int           transfers;
    int           results;
    int           full_hits;
    int           empty_hits;

    function new();
      head_slot  = 0;
      word_count = 0;
      mismatches = 0;
      transfers  = 0;
      results    = 0;
      full_hits  = 0;
      empty_hits = 0;
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction

    function void note_command(logic [2:0] op, logic [31:0] value, logic [3:0] pos);
      deque_reply_t r;
      r.word      = '0;
      r.empty_err = 1'b0;
      r.full_err  = 1'b0;
      case (op)
        OP_PUSH_BACK: begin
          if (word_count >= DEPTH) begin
            r.full_err = 1'b1;
          end else begin
            ring_word[(head_slot + word_count) % DEPTH] = value;
            word_count++;
          end
        end
        OP_PUSH_FRONT: begin
          if (word_count >= DEPTH) begin
            r.full_err = 1'b1;
          end else begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            ring_word[head_slot] = value;
            word_count++;
          end
        end
        OP_POP_BACK: begin
          if (word_count == 0) begin
            r.empty_err = 1'b1;
          end else begin
            r.word = ring_word[(head_slot + word_count - 1) % DEPTH];
            word_count--;
          end
        end
        OP_POP_FRONT: begin
          if (word_count == 0) begin
            r.empty_err = 1'b1;
          end else begin
            r.word = ring_word[head_slot];
            head_slot = (head_slot + 1) % DEPTH;
            word_count--;
          end
        end
        OP_PEEK_FRONT: begin
          if (word_count == 0) r.empty_err = 1'b1;
          else r.word = ring_word[head_slot];
        end
        OP_PEEK_BACK: begin
          if (word_count == 0) r.empty_err = 1'b1;
          else r.word = ring_word[(head_slot + word_count - 1) % DEPTH];
        end
        OP_READ_INDEX: begin
          if (int'(pos) >= word_count) r.empty_err = 1'b1;
          else r.word = ring_word[(head_slot + int'(pos)) % DEPTH];
        end
        default: begin
        end
      endcase
      r.occupancy = 5'(word_count);
      awaited_replies = {awaited_replies, r};
      transfers++;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [31:0] word, logic [4:0] occ, logic empty_err, logic full_err);
      deque_reply_t want;
      results++;
      if (empty_err) empty_hits++;
      if (full_err) full_hits++;
      if (awaited_replies.size() == 0) begin
        report_mismatch($sformatf("result word %h with no transfer waiting", word));
      end else begin
        want = awaited_replies[0];
        awaited_replies.delete(0);
        if (word !== want.word)
          report_mismatch($sformatf("word_out %h, expected %h", word, want.word));
        if (occ !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, expected %0d", occ, want.occupancy));
        if (empty_err !== want.empty_err)
          report_mismatch($sformatf("empty_error %b, expected %b", empty_err, want.empty_err));
        if (full_err !== want.full_err)
          report_mismatch($sformatf("full_error %b, expected %b", full_err, want.full_err));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_op;
  logic [31:0] in_value;
  logic [3:0]  in_position;
  logic        out_valid;
  logic [31:0] out_word_out;
  logic [4:0]  out_occupancy;
  logic        out_empty_error;
  logic        out_full_error;

  deque_scoreboard board;
  int idle_cycles = 0;

  double_ended_queue_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_word_out    (out_word_out),
    .out_occupancy   (out_occupancy),
    .out_empty_error (out_empty_error),
    .out_full_error  (out_full_error)
  );

  always #5 clk = ~clk;

  // check results and note transfers on the same edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1)
        board.check_result(out_word_out, out_occupancy, out_empty_error, out_full_error);
      if (start && busy === 1'b0)
        board.note_command(in_op, in_value, in_position);
      if (out_valid === 1'b1 || (start && busy === 1'b0)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] pick_position();
    if ($urandom_range(0, 1) == 1 && board.word_count > 0)
      return 4'($urandom_range(0, board.word_count - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [2:0] choose_op(phase_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      FILL_BIASED: begin
        if (r < 40) return OP_PUSH_BACK;
        if (r < 75) return OP_PUSH_FRONT;
        if (r < 82) return OP_POP_BACK;
        if (r < 88) return OP_POP_FRONT;
        if (r < 92) return OP_PEEK_FRONT;
        if (r < 96) return OP_PEEK_BACK;
        return OP_READ_INDEX;
      end
      DRAIN_BIASED: begin
        if (r < 12) return OP_PUSH_BACK;
        if (r < 24) return OP_PUSH_FRONT;
        if (r < 50) return OP_POP_BACK;
        if (r < 76) return OP_POP_FRONT;
        if (r < 82) return OP_PEEK_FRONT;
        if (r < 88) return OP_PEEK_BACK;
        return OP_READ_INDEX;
      end
      default: begin
        if (r < 18) return OP_PUSH_BACK;
        if (r < 36) return OP_PUSH_FRONT;
        if (r < 48) return OP_POP_BACK;
        if (r < 60) return OP_POP_FRONT;
        if (r < 70) return OP_PEEK_FRONT;
        if (r < 80) return OP_PEEK_BACK;
        if (r < 98) return OP_READ_INDEX;
        return OP_UNUSED;
      end
    endcase
  endfunction

  // hold the command until transfer, then drop start for the given gap if it is nonzero
  task automatic send_command(logic [2:0] op, logic [31:0] value, logic [3:0] pos, int gap);
    start       <= 1'b1;
    in_op       <= op;
    in_value    <= value;
    in_position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start    <= 1'b0;
      in_value <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic run_directed();
    send_command(OP_POP_BACK,   32'h1111_1111, 4'd0,  0);
    send_command(OP_POP_FRONT,  32'h2222_2222, 4'd0,  1);
    send_command(OP_PEEK_FRONT, 32'h0,         4'd0,  0);
    send_command(OP_PEEK_BACK,  32'h0,         4'd0,  0);
    send_command(OP_READ_INDEX, 32'h0,         4'd0,  2);
    send_command(OP_UNUSED,     32'hdead_beef, 4'd9,  0);
    send_command(OP_PUSH_BACK,  32'h7fff_ffff, 4'd15, 0);
    send_command(OP_PUSH_FRONT, 32'h8000_0000, 4'd0,  0);
    send_command(OP_PUSH_BACK,  32'hffff_ffff, 4'd0,  0);
    send_command(OP_PUSH_FRONT, 32'h0000_0000, 4'd0,  3);
    send_command(OP_PEEK_FRONT, 32'h0,         4'd0,  0);
    send_command(OP_PEEK_BACK,  32'h0,         4'd0,  0);
    send_command(OP_READ_INDEX, 32'h0,         4'd3,  0);
    send_command(OP_READ_INDEX, 32'h0,         4'd4,  0);
    send_command(OP_READ_INDEX, 32'h0,         4'd15, 0);
    send_command(OP_UNUSED,     32'hffff_ffff, 4'd15, 0);
    send_command(OP_POP_BACK,   32'h0,         4'd0,  0);
    send_command(OP_POP_FRONT,  32'h0,         4'd0,  0);
    wait_for_drain();
  endtask

  initial begin
    int          sent;
    int          span;
    int          gap;
    bit          calm;
    bit          pause;
    phase_mode_t mode;
    board = new();
    sent  = 0;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_op       <= OP_PUSH_BACK;
    in_value    <= '0;
    in_position <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    while (sent < RANDOM_ITEMS) begin
      mode  = (sent == 0) ? FILL_BIASED : phase_mode_t'($urandom_range(0, 2));
      span  = (sent == 0) ? 45 : $urandom_range(20, 80);
      calm  = ($urandom_range(0, 3) == 0);
      pause = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < span; i++) begin
        gap = calm ? 0 : pick_gap();
        send_command(choose_op(mode), pick_value(), pick_position(), gap);
        sent++;
      end
      if (pause) wait_for_drain();
    end

    wait_for_drain();
    repeat (3) @(posedge clk);

    $display("Covered %0d transfers and %0d results over all op codes, reserved code included.",
             board.transfers, board.results);
    $display("Results with full_error: %0d, with empty_error: %0d, mismatches: %0d.",
             board.full_hits, board.empty_hits, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
